[hdl/vtb_pkg.sv]
`default_nettype none
package vtb_pkg;

  localparam int COORD_W = 32;
  localparam int COEF_W  = 16;
  localparam int ROW_W   = 64;
  localparam int PROD_W  = COORD_W + COEF_W;
  // Three products and the constant term fit in 49 bits; one spare bit.
  localparam int ACC_W   = 50;
  localparam int FRAC_W  = 16;

  localparam logic [ROW_W-1:0] ROW0_RESET = 64'h0000_0000_0000_1000;
  localparam logic [ROW_W-1:0] ROW1_RESET = 64'h0000_0000_1000_0000;
  localparam logic [ROW_W-1:0] ROW2_RESET = 64'h0000_1000_0000_0000;
  localparam logic [ROW_W-1:0] ROW3_RESET = 64'h1000_0000_0000_0000;

  localparam logic [1:0] REG_ROW0 = 2'd0;
  localparam logic [1:0] REG_ROW1 = 2'd1;
  localparam logic [1:0] REG_ROW2 = 2'd2;
  localparam logic [1:0] REG_ROW3 = 2'd3;

  localparam logic signed [COORD_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] NEG_MAX = 32'sh8000_0000;

  typedef logic [3:0][ROW_W-1:0] rows_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic                      first_point;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic signed [COORD_W-1:0] box_min_x;
    logic signed [COORD_W-1:0] box_min_y;
    logic signed [COORD_W-1:0] box_min_z;
    logic signed [COORD_W-1:0] box_max_x;
    logic signed [COORD_W-1:0] box_max_y;
    logic signed [COORD_W-1:0] box_max_z;
    logic                      divide_error;
  } out_item_t;

  // Work handed from the front to the back: the four homogeneous sums.
  typedef struct packed {
    logic [3:0][ACC_W-1:0] acc;
    logic                  w_zero;
    logic                  first;
  } job_t;

endpackage
`default_nettype wire

[hdl/vtb_if.sv]
`default_nettype none
interface vtb_in_if;
  logic               valid;
  logic               ready;
  vtb_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface vtb_out_if;
  logic               valid;
  logic               ready;
  vtb_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hdl/vtb_front.sv]
`default_nettype none
module vtb_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire vtb_pkg::rows_t   rows,
  vtb_in_if.sink                pt_in,
  output logic                  push_valid,
  input  wire logic             push_ready,
  output vtb_pkg::job_t         push_job
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MAC  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0] state;
  logic [1:0] r;
  logic [1:0] k;
  logic       issue_done;
  logic       prod_valid;
  logic [1:0] prod_row;
  logic signed [vtb_pkg::PROD_W-1:0]  prod;
  logic signed [vtb_pkg::COORD_W-1:0] px, py, pz;
  logic       first;
  logic [3:0][vtb_pkg::ACC_W-1:0] acc;
  logic [3:0][vtb_pkg::ACC_W-1:0] acc_init;

  logic signed [vtb_pkg::COEF_W-1:0]  coef_sel;
  logic signed [vtb_pkg::COORD_W-1:0] coord_sel;

  always_comb begin
    coef_sel = rows[r][k*vtb_pkg::COEF_W +: vtb_pkg::COEF_W];
    case (k)
      2'd0:    coord_sel = px;
      2'd1:    coord_sel = py;
      default: coord_sel = pz;
    endcase
  end

  // Constant term of each row: coefficient times 1.0 in Q16.16.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      acc_init[i] = {{(vtb_pkg::ACC_W-vtb_pkg::COEF_W-vtb_pkg::FRAC_W){rows[i][vtb_pkg::ROW_W-1]}},
                     rows[i][3*vtb_pkg::COEF_W +: vtb_pkg::COEF_W], {vtb_pkg::FRAC_W{1'b0}}};
    end
  end

  assign pt_in.ready = (state == F_IDLE);
  assign push_valid  = (state == F_PUSH);
  assign push_job.acc    = acc;
  assign push_job.first  = first;
  assign push_job.w_zero = (acc[3] == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= F_IDLE;
      prod_valid <= 1'b0;
      issue_done <= 1'b0;
    end else begin
      case (state)
        F_IDLE: begin
          if (pt_in.valid) begin
            px         <= pt_in.data.point_x;
            py         <= pt_in.data.point_y;
            pz         <= pt_in.data.point_z;
            first      <= pt_in.data.first_point;
            acc        <= acc_init;
            r          <= 2'd0;
            k          <= 2'd0;
            issue_done <= 1'b0;
            state      <= F_MAC;
          end
        end
        F_MAC: begin
          if (!issue_done) begin
            prod       <= coef_sel * coord_sel;
            prod_row   <= r;
            prod_valid <= 1'b1;
            if (k == 2'd2) begin
              k <= 2'd0;
              r <= r + 2'd1;
              if (r == 2'd3) issue_done <= 1'b1;
            end else begin
              k <= k + 2'd1;
            end
          end
          if (prod_valid) begin
            acc[prod_row] <= acc[prod_row] +
              {{(vtb_pkg::ACC_W-vtb_pkg::PROD_W){prod[vtb_pkg::PROD_W-1]}}, prod};
            if (issue_done) begin
              prod_valid <= 1'b0;
              state      <= F_PUSH;
            end
          end
        end
        F_PUSH: begin
          if (push_ready) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[hdl/vtb_queue.sv]
`default_nettype none
module vtb_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire vtb_pkg::job_t push_job,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output vtb_pkg::job_t      pop_job
);

  vtb_pkg::job_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_job    = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      if (do_push && !do_pop)      count <= count + 2'd1;
      else if (do_pop && !do_push) count <= count - 2'd1;
    end
  end

endmodule
`default_nettype wire

[hdl/vtb_back.sv]
`default_nettype none
module vtb_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          pop_valid,
  output logic               pop_ready,
  input  wire vtb_pkg::job_t pop_job,
  vtb_out_if.source          res_out
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_LOAD = 3'd1;
  localparam logic [2:0] B_DIV  = 3'd2;
  localparam logic [2:0] B_BOX  = 3'd3;
  localparam logic [2:0] B_OUT  = 3'd4;

  localparam int AW = vtb_pkg::ACC_W;
  localparam int CW = vtb_pkg::COORD_W;

  logic [2:0] state;
  vtb_pkg::job_t job;
  logic [1:0] k;
  logic [4:0] cnt;
  logic [AW-1:0] rem;
  logic [AW-1:0] dmag;
  logic [CW-1:0] low;
  logic [CW-2:0] quo;
  logic          neg;
  logic          err;
  logic signed [CW-1:0] res [3];
  logic signed [CW-1:0] bmin [3];
  logic signed [CW-1:0] bmax [3];

  logic [AW-1:0] num_sel;
  logic [AW-1:0] nmag;
  logic [AW-1:0] wmag;
  logic          ovf;
  logic [AW:0]   rem_sh;
  logic          qbit;
  logic [CW-1:0] q_full;
  logic signed [CW-1:0] q_final;

  always_comb begin
    num_sel = job.acc[k];
    nmag    = num_sel[AW-1] ? AW'(-num_sel) : num_sel;
    wmag    = job.acc[3][AW-1] ? AW'(-job.acc[3]) : job.acc[3];
    ovf     = {{vtb_pkg::FRAC_W{1'b0}}, nmag} >= {wmag, {vtb_pkg::FRAC_W{1'b0}}};
    rem_sh  = {rem, low[CW-1]};
    qbit    = rem_sh >= {1'b0, dmag};
    q_full  = {quo, qbit};
    if (!neg) begin
      q_final = q_full[CW-1] ? vtb_pkg::POS_MAX : $signed(q_full);
    end else begin
      q_final = (q_full[CW-1] && q_full[CW-2:0] != '0) ? vtb_pkg::NEG_MAX
                                                      : $signed(-q_full);
    end
  end

  assign pop_ready = (state == B_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= B_IDLE;
      res_out.valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        bmin[i] <= vtb_pkg::POS_MAX;
        bmax[i] <= vtb_pkg::NEG_MAX;
      end
    end else begin
      if (res_out.valid && res_out.ready && state != B_OUT) res_out.valid <= 1'b0;
      case (state)
        B_IDLE: begin
          if (pop_valid) begin
            job <= pop_job;
            k   <= 2'd0;
            err <= pop_job.w_zero;
            if (pop_job.first) begin
              for (int i = 0; i < 3; i++) begin
                bmin[i] <= vtb_pkg::POS_MAX;
                bmax[i] <= vtb_pkg::NEG_MAX;
              end
            end
            if (pop_job.w_zero) begin
              for (int i = 0; i < 3; i++) res[i] <= '0;
              state <= B_OUT;
            end else begin
              state <= B_LOAD;
            end
          end
        end
        B_LOAD: begin
          neg  <= num_sel[AW-1] != job.acc[3][AW-1];
          dmag <= wmag;
          if (ovf) begin
            res[k] <= (num_sel[AW-1] != job.acc[3][AW-1]) ? vtb_pkg::NEG_MAX
                                                         : vtb_pkg::POS_MAX;
            if (k == 2'd2) state <= B_BOX;
            else k <= k + 2'd1;
          end else begin
            rem   <= AW'(nmag >> vtb_pkg::FRAC_W);
            low   <= {nmag[vtb_pkg::FRAC_W-1:0], {vtb_pkg::FRAC_W{1'b0}}};
            cnt   <= '0;
            state <= B_DIV;
          end
        end
        B_DIV: begin
          rem <= qbit ? AW'(rem_sh - {1'b0, dmag}) : AW'(rem_sh);
          low <= {low[CW-2:0], 1'b0};
          quo <= q_full[CW-2:0];
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            res[k] <= q_final;
            if (k == 2'd2) begin
              state <= B_BOX;
            end else begin
              k     <= k + 2'd1;
              state <= B_LOAD;
            end
          end
        end
        B_BOX: begin
          for (int i = 0; i < 3; i++) begin
            if (res[i] < bmin[i]) bmin[i] <= res[i];
            if (res[i] > bmax[i]) bmax[i] <= res[i];
          end
          state <= B_OUT;
        end
        B_OUT: begin
          if (!res_out.valid || res_out.ready) begin
            res_out.valid             <= 1'b1;
            res_out.data.out_x        <= res[0];
            res_out.data.out_y        <= res[1];
            res_out.data.out_z        <= res[2];
            res_out.data.box_min_x    <= bmin[0];
            res_out.data.box_min_y    <= bmin[1];
            res_out.data.box_min_z    <= bmin[2];
            res_out.data.box_max_x    <= bmax[0];
            res_out.data.box_max_y    <= bmax[1];
            res_out.data.box_max_z    <= bmax[2];
            res_out.data.divide_error <= err;
            state                     <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[hdl/vertex_transform_with_bounds_core.sv]
`default_nettype none
// Vertex transform with bounds: each beat on pt_in carries one Q16.16 point,
// which is multiplied as (x, y, z, 1) by the 4x4 Q4.12 matrix held in the
// four row registers, divided by the resulting w with saturation, and sent
// on res_out together with the running per-axis bounding box. A zero w gives
// a zero point, divide_error set and an untouched box (first_point still
// clears it). The front handles each point with its single shared 32x16
// multiplier doing twelve products; the back with its bit-serial divider,
// which produces the three quotients one bit per cycle (a saturating
// component finishes early). A two-deep queue between them lets the front
// accept further points while the back is dividing, and the output register
// holds a result until it is taken. Matrix writes are only to be made while
// the block is idle.
module vertex_transform_with_bounds_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  vtb_in_if.sink           pt_in,
  vtb_out_if.source        res_out
);

  vtb_pkg::rows_t rows;
  logic          push_valid;
  logic          push_ready;
  vtb_pkg::job_t push_job;
  logic          pop_valid;
  logic          pop_ready;
  vtb_pkg::job_t pop_job;

  // Matrix registers, reset to the identity.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows[0] <= vtb_pkg::ROW0_RESET;
      rows[1] <= vtb_pkg::ROW1_RESET;
      rows[2] <= vtb_pkg::ROW2_RESET;
      rows[3] <= vtb_pkg::ROW3_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        vtb_pkg::REG_ROW0: rows[0] <= cfg_data;
        vtb_pkg::REG_ROW1: rows[1] <= cfg_data;
        vtb_pkg::REG_ROW2: rows[2] <= cfg_data;
        vtb_pkg::REG_ROW3: rows[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // The front forms the four homogeneous sums and flags a zero w.
  vtb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .rows       (rows),
    .pt_in      (pt_in),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  // The queue decouples the multiply stage from the divide stage.
  vtb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  // The back divides, tracks the box and owns the output register.
  vtb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .res_out   (res_out)
  );

endmodule
`default_nettype wire

[verif/vertex_transform_with_bounds_core_test.sv]
`timescale 1ns / 1ps
// Testbench for the vertex transform core. A queue of points is filled by the
// sequencing block below; a clocked driver presents them in bursts, and a
// clocked monitor takes results under its own stall pattern and compares
// each one with the oldest prediction. The matrix is changed only while the
// core is idle, between phases.
module vertex_transform_with_bounds_core_test;

  localparam int HALF_PERIOD = 5;
  // Cycles without any beat before the run is declared hung. The back end
  // needs its bit-serial division per point, plus sender gaps and receiver stalls.
  localparam int STALL_LIMIT = 4000;
  // Settling time after the last result, covering the full pipeline depth.
  localparam int DRAIN_CYCLES = 300;
  localparam int RANDOM_PHASES = 8;
  localparam int POINTS_PER_PHASE = 185;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = vtb_pkg::REG_ROW0;
  logic [63:0] cfg_data = '0;

  vtb_in_if pt_in ();
  vtb_out_if res_out ();

  vertex_transform_with_bounds_core i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pt_in(pt_in.sink),
    .res_out(res_out.source)
  );

  always #HALF_PERIOD clk = ~clk;

  // Local copy of the matrix and the running box.
  vtb_pkg::rows_t matrix;
  logic signed [31:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;

  vtb_pkg::in_item_t point_queue[$];
  vtb_pkg::out_item_t expected_results[$];
  int errors = 0;
  int idle_cycles = 0;

  function automatic longint coefficient(logic [vtb_pkg::ROW_W-1:0] row, int slot);
    logic signed [15:0] c;
    c = row[16*slot +: 16];
    return longint'(c);
  endfunction

  // (num * 2^16) / den truncated toward zero, saturated to Q16.16.
  function automatic logic signed [31:0] q16_divide(longint num, longint den);
    logic [127:0] n, d, q, lim;
    logic neg;
    n = (num < 0) ? 128'(-num) : 128'(num);
    d = (den < 0) ? 128'(-den) : 128'(den);
    neg = (num < 0) != (den < 0);
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    q = (n << vtb_pkg::FRAC_W) / d;
    if (q > lim) q = lim;
    return neg ? -q[31:0] : q[31:0];
  endfunction

  task automatic clear_box();
    lo_x = vtb_pkg::POS_MAX; lo_y = vtb_pkg::POS_MAX; lo_z = vtb_pkg::POS_MAX;
    hi_x = vtb_pkg::NEG_MAX; hi_y = vtb_pkg::NEG_MAX; hi_z = vtb_pkg::NEG_MAX;
  endtask

  // Works out the result for one accepted point and updates the box.
  task automatic predict_vertex(input vtb_pkg::in_item_t p);
    longint sum[4];
    vtb_pkg::out_item_t r;
    if (p.first_point) clear_box();
    for (int row = 0; row < 4; row++) begin
      sum[row] = coefficient(matrix[row], 3) * 65536
               + coefficient(matrix[row], 0) * longint'(p.point_x)
               + coefficient(matrix[row], 1) * longint'(p.point_y)
               + coefficient(matrix[row], 2) * longint'(p.point_z);
    end
    r = '0;
    r.divide_error = (sum[3] == 0);
    if (!r.divide_error) begin
      r.out_x = q16_divide(sum[0], sum[3]);
      r.out_y = q16_divide(sum[1], sum[3]);
      r.out_z = q16_divide(sum[2], sum[3]);
      if (r.out_x < lo_x) lo_x = r.out_x;
      if (r.out_y < lo_y) lo_y = r.out_y;
      if (r.out_z < lo_z) lo_z = r.out_z;
      if (r.out_x > hi_x) hi_x = r.out_x;
      if (r.out_y > hi_y) hi_y = r.out_y;
      if (r.out_z > hi_z) hi_z = r.out_z;
    end
    r.box_min_x = lo_x; r.box_min_y = lo_y; r.box_min_z = lo_z;
    r.box_max_x = hi_x; r.box_max_y = hi_y; r.box_max_z = hi_z;
    expected_results.push_back(r);
  endtask

  // Driver: bursts of random length separated by random gaps. Valid is
  // assigned once per edge, so a back-to-back beat never drops in between.
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      pt_in.valid <= 1'b0;
      pt_in.data <= '0;
    end else begin
      if (pt_in.valid && pt_in.ready) predict_vertex(pt_in.data);
      if (!pt_in.valid || pt_in.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          pt_in.valid <= 1'b0;
        end else if (point_queue.size() > 0) begin
          pt_in.data <= point_queue.pop_front();
          pt_in.valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 12);
            // Some stretches run with no gaps at all.
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
          end
        end else begin
          pt_in.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [31:0] expv, logic [31:0] actv);
    if (expv !== actv) begin
      $error("%s: expected %0d, got %0d", name, $signed(expv), $signed(actv));
      errors++;
    end
  endtask

  // Monitor: the receiver runs in modes, from always ready to heavy stalls.
  int stall_mode = 0;
  int mode_left = 0;

  always @(posedge clk) begin
    vtb_pkg::out_item_t e, a;
    if (rst) begin
      res_out.ready <= 1'b0;
    end else begin
      if (res_out.valid && res_out.ready) begin
        a = res_out.data;
        if (expected_results.size() == 0) begin
          $error("result beat with no point outstanding");
          errors++;
        end else begin
          e = expected_results.pop_front();
          check_field("out_x", e.out_x, a.out_x);
          check_field("out_y", e.out_y, a.out_y);
          check_field("out_z", e.out_z, a.out_z);
          check_field("box_min_x", e.box_min_x, a.box_min_x);
          check_field("box_min_y", e.box_min_y, a.box_min_y);
          check_field("box_min_z", e.box_min_z, a.box_min_z);
          check_field("box_max_x", e.box_max_x, a.box_max_x);
          check_field("box_max_y", e.box_max_y, a.box_max_y);
          check_field("box_max_z", e.box_max_z, a.box_max_z);
          check_field("divide_error", 32'(e.divide_error), 32'(a.divide_error));
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(50, 800);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: res_out.ready <= 1'b1;
        1: res_out.ready <= ($urandom_range(0, 3) != 0);
        default: res_out.ready <= ($urandom_range(0, 40) == 0);
      endcase
    end
  end

  // Watchdog: any beat on either side counts as progress.
  always @(posedge clk) begin
    if ((pt_in.valid && pt_in.ready) || (res_out.valid && res_out.ready)) begin
      idle_cycles <= 0;
    end else if (!rst) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("vertex_transform_with_bounds_core verification failed");
        $finish;
      end
    end
  end

  task automatic write_row(logic [1:0] idx, logic [63:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    matrix[idx] = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_matrix(logic [63:0] r0, logic [63:0] r1, logic [63:0] r2,
                             logic [63:0] r3);
    write_row(vtb_pkg::REG_ROW0, r0);
    write_row(vtb_pkg::REG_ROW1, r1);
    write_row(vtb_pkg::REG_ROW2, r2);
    write_row(vtb_pkg::REG_ROW3, r3);
  endtask

  // Waits until every point has been taken and answered, then lets the
  // pipeline settle before the matrix may change.
  task automatic wait_idle();
    while (point_queue.size() > 0 || expected_results.size() > 0 || pt_in.valid)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           logic first);
    vtb_pkg::in_item_t p;
    p.point_x = x; p.point_y = y; p.point_z = z; p.first_point = first;
    point_queue.push_back(p);
  endtask

  function automatic logic [31:0] random_coord();
    case ($urandom_range(0, 7))
      0: return vtb_pkg::POS_MAX;
      1: return vtb_pkg::NEG_MAX;
      2: return 32'($signed($urandom_range(0, 8)) - 4) <<< 16;
      3, 4: return 32'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [63:0] random_row();
    logic [63:0] v;
    v = {$urandom, $urandom};
    for (int k = 0; k < 4; k++) begin
      case ($urandom_range(0, 5))
        0: v[16*k +: 16] = 16'h7FFF;
        1: v[16*k +: 16] = 16'h8000;
        2: v[16*k +: 16] = 16'h0000;
        3: v[16*k +: 16] = 16'h1000;
        default: ;
      endcase
    end
    return v;
  endfunction

  initial begin
    logic [63:0] w_row;
    matrix[0] = vtb_pkg::ROW0_RESET; matrix[1] = vtb_pkg::ROW1_RESET;
    matrix[2] = vtb_pkg::ROW2_RESET; matrix[3] = vtb_pkg::ROW3_RESET;
    clear_box();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Identity matrix straight from reset: coordinate extremes, a fresh
    // primitive, and points that extend the box in both directions.
    add_point(32'd0, 32'd0, 32'd0, 1'b1);
    add_point(vtb_pkg::POS_MAX, vtb_pkg::POS_MAX, vtb_pkg::POS_MAX, 1'b0);
    add_point(vtb_pkg::NEG_MAX, vtb_pkg::NEG_MAX, vtb_pkg::NEG_MAX, 1'b0);
    add_point(32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001, 1'b0);
    add_point(32'hFFFF_FFFF, 32'h0000_8000, 32'h7FFF_0000, 1'b1);
    wait_idle();

    // A w row of zero: every point is a divide error. A first point then
    // leaves an empty box, reported at its reset values.
    load_matrix(vtb_pkg::ROW0_RESET, vtb_pkg::ROW1_RESET, vtb_pkg::ROW2_RESET, 64'd0);
    add_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b0);
    add_point(vtb_pkg::POS_MAX, vtb_pkg::NEG_MAX, 32'd5, 1'b1);
    add_point(32'd0, 32'd0, 32'd0, 1'b0);
    wait_idle();

    // Tiny w with the largest coefficients: the quotients saturate both ways.
    load_matrix(64'h0000_0000_0000_7FFF, 64'h0000_0000_8000_0000,
                64'h0000_7FFF_0000_0000, 64'h0001_0000_0000_0000);
    add_point(vtb_pkg::POS_MAX, vtb_pkg::POS_MAX, vtb_pkg::NEG_MAX, 1'b1);
    add_point(vtb_pkg::NEG_MAX, vtb_pkg::NEG_MAX, vtb_pkg::POS_MAX, 1'b0);
    add_point(32'h0000_0001, 32'hFFFF_FFFF, 32'd0, 1'b0);
    wait_idle();

    // Every coefficient at -1 LSB, then at the most negative value (row 2 at the most positive).
    load_matrix('1, '1, '1, '1);
    add_point(32'h0001_0000, vtb_pkg::NEG_MAX, vtb_pkg::POS_MAX, 1'b1);
    add_point(32'hFFFF_0000, 32'd7, 32'd0, 1'b0);
    wait_idle();
    load_matrix({4{16'h8000}}, {4{16'h8000}}, {4{16'h7FFF}}, {4{16'h8000}});
    add_point(vtb_pkg::POS_MAX, 32'd0, 32'd0, 1'b1);
    add_point(32'd0, vtb_pkg::NEG_MAX, 32'd1, 1'b0);
    add_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    wait_idle();

    // Random phases. Some use a w row that depends on z alone, so a zero z
    // gives a zero w and divide errors turn up often.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph % 4)
        0: w_row = 64'h1000_0000_0000_0000 | 64'($urandom_range(0, 255));
        1: w_row = 64'(16'($urandom_range(1, 16'hFFFF))) << 32;
        default: w_row = random_row();
      endcase
      load_matrix(random_row(), random_row(), random_row(), w_row);
      for (int i = 0; i < POINTS_PER_PHASE; i++) begin
        add_point(random_coord(), random_coord(),
                  ($urandom_range(0, 5) == 0) ? 32'd0 : random_coord(),
                  $urandom_range(0, 7) == 0);
      end
      wait_idle();
    end

    // Back to the identity so the reset values are written explicitly too.
    load_matrix(vtb_pkg::ROW0_RESET, vtb_pkg::ROW1_RESET, vtb_pkg::ROW2_RESET,
                vtb_pkg::ROW3_RESET);
    for (int i = 0; i < 20; i++)
      add_point(random_coord(), random_coord(), random_coord(), i == 0);
    wait_idle();

    if (errors == 0) begin
      $display("vertex_transform_with_bounds_core verification clean");
    end else begin
      $display("vertex_transform_with_bounds_core verification failed");
    end
    $finish;
  end

endmodule

[files.f]
hdl/vtb_pkg.sv
hdl/vtb_if.sv
hdl/vtb_front.sv
hdl/vtb_queue.sv
hdl/vtb_back.sv
hdl/vertex_transform_with_bounds_core.sv
verif/vertex_transform_with_bounds_core_test.sv
